### rtl/ppmfd_pkg.sv
// ppmfd_pkg: shared types and constants for the ppm frame decoder
// no dependencies; imported by every module under rtl/
package ppmfd_pkg;

  localparam int unsigned ChannelsDefault = 6;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned PulseW          = 16;
  localparam int unsigned ChanW           = 3;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [PulseW-1:0] MinPulseReset  = 16'd700;
  localparam logic [PulseW-1:0] MaxPulseReset  = 16'd2250;
  localparam logic [PulseW-1:0] SyncPulseReset = 16'd7500;
  localparam logic [PulseW-1:0] StoreReset     = 16'd1500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PULSE  = 2'd0,
    REG_MAX_PULSE  = 2'd1,
    REG_SYNC_PULSE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_IGNORED = 3'd1,
    KIND_ERROR   = 3'd2,
    KIND_COMMIT  = 3'd3,
    KIND_DROPPED = 3'd4
  } kind_e;

  // operation of the shared subtract/compare unit
  typedef enum logic [1:0] {
    OP_DIFF    = 2'd0,
    OP_LT_MIN  = 2'd1,
    OP_GT_MAX  = 2'd2,
    OP_LT_SYNC = 2'd3
  } cmp_op_e;

  typedef struct packed {
    logic [TimeW-1:0]  edge_time;
    logic [TimeW-1:0]  last_time;
    logic [TimeW-1:0]  width;
    logic [PulseW-1:0] min_pulse;
    logic [PulseW-1:0] max_pulse;
    logic [PulseW-1:0] sync_pulse;
  } cmp_opnd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DIFF = 3'd1,
    ST_MIN  = 3'd2,
    ST_MAX  = 3'd3,
    ST_SYNC = 3'd4,
    ST_EXEC = 3'd5,
    ST_OUT  = 3'd6
  } state_e;

endpackage

### rtl/ppmfd_cmp_unit.sv
// ppmfd_cmp_unit: one 32-bit subtractor shared by the width and limit checks
// depends on ppmfd_pkg
module ppmfd_cmp_unit (
  input  ppmfd_pkg::cmp_op_e             op_i,
  input  ppmfd_pkg::cmp_opnd_t           opnd_i,
  output logic [ppmfd_pkg::TimeW-1:0]    diff_o,
  output logic                           borrow_o
);
  import ppmfd_pkg::*;

  logic [TimeW-1:0] a, b;
  logic [TimeW:0]   res;

  always_comb begin
    unique case (op_i)
      OP_DIFF: begin
        a = opnd_i.edge_time;
        b = opnd_i.last_time;
      end
      OP_LT_MIN: begin
        a = opnd_i.width;
        b = TimeW'(opnd_i.min_pulse);
      end
      // borrow set when max < width
      OP_GT_MAX: begin
        a = TimeW'(opnd_i.max_pulse);
        b = opnd_i.width;
      end
      OP_LT_SYNC: begin
        a = opnd_i.width;
        b = TimeW'(opnd_i.sync_pulse);
      end
      default: begin
        a = opnd_i.edge_time;
        b = opnd_i.last_time;
      end
    endcase
  end

  assign res      = {1'b0, a} - {1'b0, b};
  assign diff_o   = res[TimeW-1:0];
  assign borrow_o = res[TimeW];

endmodule

### rtl/ppmfd_chan_store.sv
// ppmfd_chan_store: per-channel pulse width registers, one write and one read port
// depends on ppmfd_pkg
module ppmfd_chan_store #(
  parameter int unsigned CHANNELS = ppmfd_pkg::ChannelsDefault,
  parameter int unsigned IdxW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [IdxW-1:0]               waddr_i,
  input  logic [ppmfd_pkg::PulseW-1:0]  wdata_i,
  input  logic [IdxW-1:0]               raddr_i,
  output logic [ppmfd_pkg::PulseW-1:0]  rdata_o
);
  import ppmfd_pkg::*;

  logic [PulseW-1:0] store_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) store_q[i] <= StoreReset;
    end else if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = store_q[raddr_i];

endmodule

### rtl/ppm_frame_decoder.sv
// ppm_frame_decoder: top level, sequencer around the shared compare unit
// depends on ppmfd_pkg, ppmfd_cmp_unit, ppmfd_chan_store
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o    | edge_time_i
//  out     | out_valid_o / out_stall_i  | kind_o channel_o width_o error_total_o last_o
//  cfg     | cfg_we_i (no wait)         | cfg_index_i cfg_data_i
//
// an edge goes through the shared subtractor (difference, then three limit checks),
// then the update, before its first result beat shows; a sync that commits
// then gives CHANNELS beats, one per cycle when out_stall_i stays low. the input
// stalls from accept until the last result beat is taken. reset restores the limit
// registers, the counter (CHANNELS) and every stored width (1500).
module ppm_frame_decoder #(
  parameter int unsigned CHANNELS = ppmfd_pkg::ChannelsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ppmfd_pkg::TimeW-1:0]          edge_time_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           kind_o,
  output logic [ppmfd_pkg::ChanW-1:0]          channel_o,
  output logic [ppmfd_pkg::PulseW-1:0]         width_o,
  output logic [ppmfd_pkg::PulseW-1:0]         error_total_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ppmfd_pkg::PulseW-1:0]         cfg_data_i
);
  import ppmfd_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(CHANNELS + 2);
  localparam logic [CntW-1:0] CntFull   = CntW'(CHANNELS);
  localparam logic [CntW-1:0] CntPoison = CntW'(CHANNELS + 1);
  localparam logic [IdxW-1:0] IdxLast   = IdxW'(CHANNELS - 1);

  // configuration
  logic [PulseW-1:0] min_q, max_q, sync_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MinPulseReset;
      max_q  <= MaxPulseReset;
      sync_q <= SyncPulseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_PULSE:  min_q  <= cfg_data_i;
        REG_MAX_PULSE:  max_q  <= cfg_data_i;
        REG_SYNC_PULSE: sync_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e            state_q, state_d;
  logic [TimeW-1:0]  edge_q, edge_d;
  logic [TimeW-1:0]  last_time_q, last_time_d;
  logic [TimeW-1:0]  w_q, w_d;
  logic              lt_min_q, lt_min_d;
  logic              gt_max_q, gt_max_d;
  logic              lt_sync_q, lt_sync_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PulseW-1:0] err_q, err_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [ChanW-1:0]  chan_q, chan_d;
  logic [PulseW-1:0] width_q, width_d;
  logic              last_q, last_d;

  cmp_op_e           op;
  cmp_opnd_t         opnd;
  logic [TimeW-1:0]  diff;
  logic              borrow;

  logic              st_we;
  logic [IdxW-1:0]   st_raddr;
  logic [PulseW-1:0] st_rdata;

  logic              bad;
  logic [CntW-1:0]   cnt_eff;
  logic [PulseW-1:0] sat;
  logic [IdxW-1:0]   idx_nxt;

  assign opnd = '{edge_time:  edge_q,
                  last_time:  last_time_q,
                  width:      w_q,
                  min_pulse:  min_q,
                  max_pulse:  max_q,
                  sync_pulse: sync_q};

  ppmfd_cmp_unit u_cmp (
    .op_i     (op),
    .opnd_i   (opnd),
    .diff_o   (diff),
    .borrow_o (borrow)
  );

  ppmfd_chan_store #(
    .CHANNELS (CHANNELS),
    .IdxW     (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (cnt_eff[IdxW-1:0]),
    .wdata_i (sat),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign bad     = lt_min_q | (gt_max_q & lt_sync_q);
  assign cnt_eff = bad ? CntPoison : cnt_q;
  assign sat     = (w_q[TimeW-1:PulseW] != '0) ? '1 : w_q[PulseW-1:0];
  assign idx_nxt = idx_q + IdxW'(1);

  always_comb begin
    state_d     = state_q;
    edge_d      = edge_q;
    last_time_d = last_time_q;
    w_d         = w_q;
    lt_min_d    = lt_min_q;
    gt_max_d    = gt_max_q;
    lt_sync_d   = lt_sync_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    chan_d      = chan_q;
    width_d     = width_q;
    last_d      = last_q;
    op          = OP_DIFF;
    st_we       = 1'b0;
    st_raddr    = idx_nxt;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          edge_d  = edge_time_i;
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        op      = OP_DIFF;
        w_d     = diff;
        state_d = ST_MIN;
      end
      ST_MIN: begin
        op       = OP_LT_MIN;
        lt_min_d = borrow;
        state_d  = ST_MAX;
      end
      ST_MAX: begin
        op       = OP_GT_MAX;
        gt_max_d = borrow;
        state_d  = ST_SYNC;
      end
      ST_SYNC: begin
        op        = OP_LT_SYNC;
        lt_sync_d = borrow;
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        st_raddr    = '0;
        last_time_d = edge_q;
        out_valid_d = 1'b1;
        state_d     = ST_OUT;
        if (bad) err_d = err_q + PulseW'(1);
        if (!lt_sync_q) begin
          // sync gap: commit the frame unless it was poisoned
          cnt_d = '0;
          if (cnt_eff <= CntFull) begin
            idx_d   = '0;
            kind_d  = KIND_COMMIT;
            chan_d  = '0;
            width_d = st_rdata;
            last_d  = (CHANNELS == 1);
          end else begin
            kind_d  = KIND_DROPPED;
            chan_d  = ChanW'(cnt_eff);
            width_d = sat;
            last_d  = 1'b1;
          end
        end else if (cnt_eff < CntFull) begin
          st_we   = 1'b1;
          cnt_d   = cnt_eff + CntW'(1);
          kind_d  = KIND_STORED;
          chan_d  = ChanW'(cnt_eff);
          width_d = sat;
          last_d  = 1'b1;
        end else begin
          cnt_d   = cnt_eff;
          kind_d  = bad ? KIND_ERROR : KIND_IGNORED;
          chan_d  = ChanW'(cnt_eff);
          width_d = sat;
          last_d  = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (!last_q) begin
            // next committed channel beat
            idx_d   = idx_nxt;
            chan_d  = ChanW'(idx_nxt);
            width_d = st_rdata;
            last_d  = (idx_nxt == IdxLast);
          end else begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_time_q <= '0;
      cnt_q       <= CntFull;
      err_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q    <= edge_d;
    w_q       <= w_d;
    lt_min_q  <= lt_min_d;
    gt_max_q  <= gt_max_d;
    lt_sync_q <= lt_sync_d;
    kind_q    <= kind_d;
    chan_q    <= chan_d;
    width_q   <= width_d;
    last_q    <= last_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign channel_o     = chan_q;
  assign width_o       = width_q;
  assign error_total_o = err_q;
  assign last_o        = last_q;

  // a result beat never overlaps acceptance of a new edge
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("edge accepted while a result beat is pending");

  // error count only ever steps by one
  a_err_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(error_total_o) |-> error_total_o == PulseW'($past(error_total_o) + 16'd1))
    else $error("error count jumped");

  // the final beat of an edge closes the result run
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("result beat after last");

  // commit runs count channels upward by one
  a_commit_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && kind_o == KIND_COMMIT &&
      channel_o == ChanW'($past(channel_o) + 3'd1))
    else $error("commit channel order broken");

endmodule
